// ----- sv/bstm_pkg.sv -----
// ----------------------------------------------------------------------------
// bstm_pkg: shared types and constants of the box sum template matcher
// Field widths, register codes, row store port numbering and the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bstm_pkg;

  // Stream and configuration widths.
  localparam int PIX_W       = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;

  // Register field widths.
  localparam int IMG_DIM_W = 11;
  localparam int TPL_DIM_W = 7;
  localparam int TSUM_W    = 20;
  localparam int FRAC_W    = 17;

  // Arithmetic widths.
  localparam int INT_W      = 28;  // integral image entry, wraps modulo 2^28
  localparam int RSUM_W     = 18;  // running sum along one row
  localparam int AREA_W     = 2 * TPL_DIM_W;
  localparam int FULL_W     = AREA_W + PIX_W;  // 255 times the area
  localparam int RHS_W      = FULL_W + FRAC_W;
  localparam int DIFF_W     = INT_W;
  localparam int FRAC_SHIFT = 16;
  localparam int LHS_W      = DIFF_W + FRAC_SHIFT;
  localparam int COORD_W    = 10;
  localparam int BEST_OUT_W = 20;

  localparam int TPL_DIM_MAX = (1 << TPL_DIM_W) - 1;

  localparam logic [FRAC_W-1:0]    FRAC_ONE    = 17'd65536;
  localparam logic [IMG_DIM_W-1:0] IMG_DIM_RST = 11'd1024;
  localparam logic [TPL_DIM_W-1:0] TPL_DIM_RST = 7'd8;
  localparam logic [TSUM_W-1:0]    TSUM_RST    = 20'd0;
  localparam logic [FRAC_W-1:0]    FRAC_RST    = 17'd52429;

  // Row store read ports.
  localparam int NUM_RD   = 4;
  localparam int RD_ABOVE = 0;
  localparam int RD_LEFT  = 1;
  localparam int RD_UP    = 2;
  localparam int RD_DIAG  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH     = 3'd0,
    CFG_IMAGE_HEIGHT    = 3'd1,
    CFG_TEMPLATE_WIDTH  = 3'd2,
    CFG_TEMPLATE_HEIGHT = 3'd3,
    CFG_TEMPLATE_SUM    = 3'd4,
    CFG_MATCH_FRACTION  = 3'd5
  } cfg_idx_e;

  // One result beat; found sits in the lowest bit.
  typedef struct packed {
    logic [BEST_OUT_W-1:0] best_diff;
    logic [COORD_W-1:0]    match_y;
    logic [COORD_W-1:0]    match_x;
    logic                  found;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

`default_nettype wire

// ----- sv/bstm_row_store.sv -----
// ----------------------------------------------------------------------------
// bstm_row_store: ring of integral image rows
// Four identical copies share one write port; each copy serves one read port
// with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bstm_row_store #(
  parameter int ADDR_W = 17,
  parameter int DEPTH  = 66560
) (
  input  logic                                              clk_i,
  input  logic                                              wr_en_i,
  input  logic [ADDR_W-1:0]                                 wr_addr_i,
  input  logic [bstm_pkg::INT_W-1:0]                        wr_data_i,
  input  logic [bstm_pkg::NUM_RD-1:0][ADDR_W-1:0]           rd_addr_i,
  output logic [bstm_pkg::NUM_RD-1:0][bstm_pkg::INT_W-1:0]  rd_data_o
);
  import bstm_pkg::*;

  for (genvar g = 0; g < NUM_RD; g++) begin : g_copy
    logic [INT_W-1:0] mem [DEPTH];
    logic [INT_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_en_i) begin
        mem[wr_addr_i] <= wr_data_i;
      end
      rd_q <= mem[rd_addr_i[g]];
    end

    assign rd_data_o[g] = rd_q;
  end

endmodule

`default_nettype wire

// ----- sv/box_sum_template_matcher.sv -----
// ----------------------------------------------------------------------------
// box_sum_template_matcher: streaming integral-image template matcher
// Builds integral image rows from a raster pixel stream, scores every box of
// template size against the template sum and reports the best box per frame.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Beat content (lowest bits first)
// s_axis    in   tdata[7:0] pixel
// m_axis    out  tdata[0] found, [10:1] match_x, [20:11] match_y,
//                [40:21] best_diff, [47:41] zero
// cfg       in   cfg_idx_i selects the register, cfg_data_i holds its value
//
// One pixel is taken every clock cycle while s_axis_tready_o is high. A pixel
// flows through a five stage pipeline: row store read, integral sum and store
// write, box sum, absolute difference, threshold compare and best update. The
// frame result enters an eight entry result queue as the last pixel's beat
// leaves the compare stage, then is offered on m_axis. s_axis_tready_o drops
// only while eight frame results are queued or still in the pipeline, so a
// stalled m_axis side holds up the input after eight frames. Reset clears the
// position counters, the best box state and the queue; the row store is not
// cleared, as every entry is written before it is read. Registers are to be
// written only between frames while the pipeline is empty; it is not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module box_sum_template_matcher #(
  parameter int MAX_IMAGE_WIDTH     = 1024,
  parameter int MAX_IMAGE_HEIGHT    = 1024,
  parameter int MAX_TEMPLATE_WIDTH  = 64,
  parameter int MAX_TEMPLATE_HEIGHT = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Pixel stream.
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [bstm_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,   // [7:0] pixel
  // Result stream.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] found, [10:1] match_x, [20:11] match_y, [40:21] best_diff, [47:41] zero
  output logic [bstm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // Register write port.
  input  logic                               cfg_we_i,
  input  logic [bstm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bstm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import bstm_pkg::*;

  // Column, row and ring row widths follow the size limits.
  localparam int CW     = $clog2(MAX_IMAGE_WIDTH);
  localparam int RHW    = $clog2(MAX_IMAGE_HEIGHT);
  localparam int RING   = MAX_TEMPLATE_HEIGHT + 1;
  localparam int RW     = $clog2(RING);
  localparam int AW     = RW + CW;
  localparam int DEPTH  = RING * (2 ** CW);
  localparam int TW_LIM = (MAX_TEMPLATE_WIDTH > TPL_DIM_MAX) ? TPL_DIM_MAX
                                                              : MAX_TEMPLATE_WIDTH;
  localparam int TH_LIM = (MAX_TEMPLATE_HEIGHT > TPL_DIM_MAX) ? TPL_DIM_MAX
                                                               : MAX_TEMPLATE_HEIGHT;
  localparam int QDEPTH = 8;
  localparam int QPW    = $clog2(QDEPTH);

  // Position and box flags of one pixel as it moves down the pipeline.
  typedef struct packed {
    logic           first;
    logic           last;
    logic           box_ok;
    logic [CW-1:0]  col;
    logic [RHW-1:0] row;
  } tag_t;

  // Which neighbors of the box exist for this pixel.
  typedef struct packed {
    logic above;
    logic left;
    logic up;
  } nbr_t;

  // Step a ring row index back by k rows.
  function automatic logic [RW-1:0] ring_back(logic [RW-1:0] r, logic [TPL_DIM_W-1:0] k);
    logic [RW:0] t;
    t = {1'b0, r} - (RW + 1)'(k);
    if (t[RW]) begin
      t = t + (RW + 1)'(RING);
    end
    return t[RW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [IMG_DIM_W-1:0] img_w_q, img_h_q;
  logic [TPL_DIM_W-1:0] tpl_w_q, tpl_h_q;
  logic [TSUM_W-1:0]    tsum_q;
  logic [FRAC_W-1:0]    frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= IMG_DIM_RST;
      img_h_q <= IMG_DIM_RST;
      tpl_w_q <= TPL_DIM_RST;
      tpl_h_q <= TPL_DIM_RST;
      tsum_q  <= TSUM_RST;
      frac_q  <= FRAC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:     img_w_q <= cfg_data_i[IMG_DIM_W-1:0];
        CFG_IMAGE_HEIGHT:    img_h_q <= cfg_data_i[IMG_DIM_W-1:0];
        CFG_TEMPLATE_WIDTH:  tpl_w_q <= cfg_data_i[TPL_DIM_W-1:0];
        CFG_TEMPLATE_HEIGHT: tpl_h_q <= cfg_data_i[TPL_DIM_W-1:0];
        CFG_TEMPLATE_SUM:    tsum_q  <= cfg_data_i[TSUM_W-1:0];
        CFG_MATCH_FRACTION:  frac_q  <= cfg_data_i[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero counts as one, oversize saturates to the limit.
  logic [CW:0]          w_eff;
  logic [RHW:0]         h_eff;
  logic [TPL_DIM_W-1:0] tw_eff, th_eff;

  always_comb begin
    if (img_w_q == '0) begin
      w_eff = (CW + 1)'(1);
    end else if (32'(img_w_q) > MAX_IMAGE_WIDTH) begin
      w_eff = (CW + 1)'(MAX_IMAGE_WIDTH);
    end else begin
      w_eff = (CW + 1)'(img_w_q);
    end

    if (img_h_q == '0) begin
      h_eff = (RHW + 1)'(1);
    end else if (32'(img_h_q) > MAX_IMAGE_HEIGHT) begin
      h_eff = (RHW + 1)'(MAX_IMAGE_HEIGHT);
    end else begin
      h_eff = (RHW + 1)'(img_h_q);
    end

    if (tpl_w_q == '0) begin
      tw_eff = TPL_DIM_W'(1);
    end else if (32'(tpl_w_q) > TW_LIM) begin
      tw_eff = TPL_DIM_W'(TW_LIM);
    end else begin
      tw_eff = tpl_w_q;
    end

    if (tpl_h_q == '0) begin
      th_eff = TPL_DIM_W'(1);
    end else if (32'(tpl_h_q) > TH_LIM) begin
      th_eff = TPL_DIM_W'(TH_LIM);
    end else begin
      th_eff = tpl_h_q;
    end
  end

  // Threshold terms, two registered multiplications into area_q and then rhs_q.
  // They settle after a write, well before the first pixel reaches the compare.
  logic [AREA_W-1:0] area_q;
  logic [FULL_W-1:0] full;
  logic [FRAC_W-1:0] frac_eff, frac_rem;
  logic [RHS_W-1:0]  rhs_q;

  assign full     = (FULL_W'(area_q) << PIX_W) - FULL_W'(area_q);
  assign frac_eff = (frac_q > FRAC_ONE) ? FRAC_ONE : frac_q;
  assign frac_rem = FRAC_ONE - frac_eff;

  always_ff @(posedge clk_i) begin
    area_q <= AREA_W'(tw_eff) * AREA_W'(th_eff);
    rhs_q  <= RHS_W'(full) * RHS_W'(frac_rem);
  end

  // --------------------------------------------------------------------------
  // Raster position and row running sum, stepped on every accepted beat
  // --------------------------------------------------------------------------
  logic [CW-1:0]     col_q;
  logic [RHW-1:0]    row_q;
  logic [RW-1:0]     ring_q;
  logic [RSUM_W-1:0] rsum_q;
  logic              s_acc;
  logic              col_last, row_last, pix_last;
  logic [RSUM_W-1:0] rsum_d;
  tag_t              tag_in;
  nbr_t              nbr_in;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign col_last = ((CW + 1)'(col_q) + (CW + 1)'(1)) >= w_eff;
  assign row_last = ((RHW + 1)'(row_q) + (RHW + 1)'(1)) >= h_eff;
  assign pix_last = col_last && row_last;
  assign rsum_d   = ((col_q == '0) ? '0 : rsum_q) + RSUM_W'(s_axis_tdata_i[PIX_W-1:0]);

  always_comb begin
    tag_in.first  = (col_q == '0) && (row_q == '0);
    tag_in.last   = pix_last;
    tag_in.box_ok = (32'(col_q) + 1 >= 32'(tw_eff)) && (32'(row_q) + 1 >= 32'(th_eff));
    tag_in.col    = col_q;
    tag_in.row    = row_q;
    nbr_in.above  = (row_q != '0);
    nbr_in.left   = 32'(col_q) >= 32'(tw_eff);
    nbr_in.up     = 32'(row_q) >= 32'(th_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ring_q <= '0;
      rsum_q <= '0;
    end else if (s_acc) begin
      rsum_q <= rsum_d;
      if (col_last) begin
        col_q <= '0;
        if (row_last) begin
          row_q  <= '0;
          ring_q <= '0;
        end else begin
          row_q  <= row_q + RHW'(1);
          ring_q <= (ring_q == RW'(RING - 1)) ? '0 : ring_q + RW'(1);
        end
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Row store addressing. Reads go out every cycle from the current position;
  // the data is used only when a pixel was accepted at that edge.
  // --------------------------------------------------------------------------
  logic [RW-1:0]               ring_m1, ring_mth;
  logic [CW-1:0]               col_mtw;
  logic [AW-1:0]               wr_addr_in;
  logic [NUM_RD-1:0][AW-1:0]   rd_addr;
  logic [NUM_RD-1:0][INT_W-1:0] rd_data;

  assign ring_m1    = ring_back(ring_q, TPL_DIM_W'(1));
  assign ring_mth   = ring_back(ring_q, th_eff);
  assign col_mtw    = col_q - CW'(tw_eff);
  assign wr_addr_in = {ring_q, col_q};

  always_comb begin
    rd_addr[RD_ABOVE] = {ring_m1, col_q};
    rd_addr[RD_LEFT]  = {ring_q, col_mtw};
    rd_addr[RD_UP]    = {ring_mth, col_q};
    rd_addr[RD_DIAG]  = {ring_mth, col_mtw};
  end

  // --------------------------------------------------------------------------
  // Stage 1: row store data arrives. The pixel just ahead writes its integral
  // entry at the same edge this one reads, so a matching address takes the
  // written value from stage 2 instead.
  // --------------------------------------------------------------------------
  logic              p1_v_q;
  tag_t              p1_tag_q;
  nbr_t              p1_nbr_q;
  logic [RSUM_W-1:0] p1_rsum_q;
  logic [AW-1:0]     p1_addr_q;
  logic [NUM_RD-1:0] p1_hit_q;
  logic [NUM_RD-1:0] hit_in;

  // Stage 2 registers, declared here for the bypass.
  logic              p2_v_q;
  tag_t              p2_tag_q;
  logic [INT_W-1:0]  p2_here_q;
  logic [INT_W-1:0]  p2_nd_q;

  always_comb begin
    for (int i = 0; i < NUM_RD; i++) begin
      hit_in[i] = p1_v_q && (rd_addr[i] == p1_addr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else begin
      p1_v_q <= s_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      p1_tag_q  <= tag_in;
      p1_nbr_q  <= nbr_in;
      p1_rsum_q <= rsum_d;
      p1_addr_q <= wr_addr_in;
      p1_hit_q  <= hit_in;
    end
  end

  logic [NUM_RD-1:0][INT_W-1:0] nb_val;
  logic [INT_W-1:0]             above, left, up, diag, here;

  always_comb begin
    for (int i = 0; i < NUM_RD; i++) begin
      nb_val[i] = p1_hit_q[i] ? p2_here_q : rd_data[i];
    end
    above = p1_nbr_q.above ? nb_val[RD_ABOVE] : '0;
    left  = p1_nbr_q.left ? nb_val[RD_LEFT] : '0;
    up    = p1_nbr_q.up ? nb_val[RD_UP] : '0;
    diag  = (p1_nbr_q.up && p1_nbr_q.left) ? nb_val[RD_DIAG] : '0;
    here  = INT_W'(p1_rsum_q) + above;
  end

  bstm_row_store #(
    .ADDR_W (AW),
    .DEPTH  (DEPTH)
  ) u_row_store (
    .clk_i     (clk_i),
    .wr_en_i   (p1_v_q),
    .wr_addr_i (p1_addr_q),
    .wr_data_i (here),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // --------------------------------------------------------------------------
  // Stages 2 to 4: box sum and absolute difference, all modulo 2^28.
  // --------------------------------------------------------------------------
  logic             p3_v_q;
  tag_t             p3_tag_q;
  logic [INT_W-1:0] p3_box_q;
  logic             p4_v_q;
  tag_t             p4_tag_q;
  logic [DIFF_W-1:0] p4_diff_q;
  logic [DIFF_W-1:0] diff;

  assign diff = (p3_box_q >= INT_W'(tsum_q)) ? p3_box_q - INT_W'(tsum_q)
                                             : INT_W'(tsum_q) - p3_box_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
    end else begin
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_tag_q  <= p1_tag_q;
    p2_here_q <= here;
    p2_nd_q   <= diag - left - up;
    p3_tag_q  <= p2_tag_q;
    p3_box_q  <= p2_here_q + p2_nd_q;
    p4_tag_q  <= p3_tag_q;
    p4_diff_q <= diff;
  end

  // --------------------------------------------------------------------------
  // Stage 5: threshold compare and best box update. The first pixel of a
  // frame starts from 255 times the area with no match. A tie keeps the
  // earlier box because the difference must be strictly smaller.
  // --------------------------------------------------------------------------
  logic [FULL_W-1:0] best_q, best_base, best_d;
  logic [CW-1:0]     bcol_q, bcol_base, bcol_d;
  logic [RHW-1:0]    brow_q, brow_base, brow_d;
  logic              seen_q, seen_base, seen_d;
  logic              thr_ok, better, take;
  result_t           res_in;
  logic [31:0]       bcol_ext, brow_ext;

  always_comb begin
    best_base = p4_tag_q.first ? full : best_q;
    bcol_base = p4_tag_q.first ? '0 : bcol_q;
    brow_base = p4_tag_q.first ? '0 : brow_q;
    seen_base = p4_tag_q.first ? 1'b0 : seen_q;
    thr_ok    = {p4_diff_q, FRAC_SHIFT'(0)} < LHS_W'(rhs_q);
    better    = p4_diff_q < DIFF_W'(best_base);
    take      = p4_tag_q.box_ok && thr_ok && better;
    best_d    = take ? FULL_W'(p4_diff_q) : best_base;
    bcol_d    = take ? p4_tag_q.col : bcol_base;
    brow_d    = take ? p4_tag_q.row : brow_base;
    seen_d    = take || seen_base;

    bcol_ext         = 32'(bcol_d);
    brow_ext         = 32'(brow_d);
    res_in.found     = seen_d;
    res_in.match_x   = seen_d ? bcol_ext[COORD_W-1:0] : '0;
    res_in.match_y   = seen_d ? brow_ext[COORD_W-1:0] : '0;
    res_in.best_diff = BEST_OUT_W'(best_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      bcol_q <= '0;
      brow_q <= '0;
      seen_q <= 1'b0;
    end else if (p4_v_q) begin
      best_q <= best_d;
      bcol_q <= bcol_d;
      brow_q <= brow_d;
      seen_q <= seen_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue. A slot is reserved when the last pixel of a frame is
  // accepted, so a result never finds the queue full.
  // --------------------------------------------------------------------------
  result_t          q_mem [QDEPTH];
  logic [QPW-1:0]   q_wr_q, q_rd_q;
  logic [QPW:0]     q_cnt_q, resv_q;
  logic             q_push, q_pop;

  assign q_push = p4_v_q && p4_tag_q.last;
  assign q_pop  = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i) begin
    if (q_push) begin
      q_mem[q_wr_q] <= res_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
      resv_q  <= '0;
    end else begin
      if (q_push) begin
        q_wr_q <= q_wr_q + QPW'(1);
      end
      if (q_pop) begin
        q_rd_q <= q_rd_q + QPW'(1);
      end
      q_cnt_q <= q_cnt_q + (QPW + 1)'(q_push) - (QPW + 1)'(q_pop);
      resv_q  <= resv_q + (QPW + 1)'(s_acc && pix_last) - (QPW + 1)'(q_pop);
    end
  end

  assign s_axis_tready_o = resv_q < (QPW + 1)'(QDEPTH);
  assign m_axis_tvalid_o = q_cnt_q != '0;
  assign m_axis_tdata_o  = OUT_TDATA_W'(q_mem[q_rd_q]);

endmodule

`default_nettype wire

// ----- sv/bstm_checker.sv -----
// ----------------------------------------------------------------------------
// bstm_checker: port level checks of the box sum template matcher
// Watches the result stream and the input back-pressure over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bstm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [bstm_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import bstm_pkg::*;

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // Without a match the reported corner is zero.
  a_no_match_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[2*COORD_W:1] == '0)
    else $error("corner reported without a match");

  // The input is held off while results are queued or still in the pipeline; this check demands a result on offer.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o ##1 m_axis_tvalid_o)
    else $error("input stalled with no result pending");

endmodule

bind box_sum_template_matcher bstm_checker u_bstm_checker (.*);

`default_nettype wire
